FILE: design/tgwg_pkg.sv
// Shared types, constants and word functions of the twisted GFSR generator.
package tgwg_pkg;

  localparam int unsigned TGWG_TABLE_WORDS = 624;
  localparam int unsigned TGWG_TAP_OFFSET  = 397;
  localparam int unsigned WORD_W           = 32;

  localparam logic CMD_SEED = 1'b0;
  localparam logic CMD_NEXT = 1'b1;

  localparam logic [WORD_W-1:0] SEED_MULT  = 32'd1812433253;
  localparam logic [WORD_W-1:0] UPPER_BIT  = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOWER_BITS = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] TWIST_XOR  = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C   = 32'hefc6_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_TWIST
  } ctrl_state_e;

  typedef struct packed {
    logic seed_load;     // latch seed word, restart fill
    logic next_read;     // issue ring reads for a next request
    logic seed_write;    // write one ring entry of the fill
    logic twist_commit;  // write twisted word, load result, advance pointer
  } ctrl_cmd_t;

  typedef struct packed {
    logic seed_last;
  } dp_status_t;

  function automatic logic [WORD_W-1:0] seed_step(input logic [WORD_W-1:0] s,
                                                  input logic [WORD_W-1:0] i);
    logic [WORD_W-1:0] x;
    x = (s ^ (s << 30)) + i;
    return SEED_MULT * x;
  endfunction

  function automatic logic [WORD_W-1:0] twist(input logic [WORD_W-1:0] v,
                                              input logic [WORD_W-1:0] p,
                                              input logic [WORD_W-1:0] t);
    logic [WORD_W-1:0] y;
    y = (v & UPPER_BIT) | (p & LOWER_BITS);
    return t ^ (y >> 1) ^ (p[0] ? TWIST_XOR : '0);
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] v);
    return v ^ (v >> 11) ^ ((v << 7) & TEMPER_B) ^ ((v << 15) & TEMPER_C) ^ (v >> 18);
  endfunction

endpackage

FILE: design/tgwg_req_if.sv
// Request channel: command and seed word with valid/ready.
interface tgwg_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] seed_value;

  modport source (output valid, command, seed_value, input ready);
  modport sink (input valid, command, seed_value, output ready);
endinterface

FILE: design/tgwg_rsp_if.sv
// Result channel: tempered random word with valid/ready.
interface tgwg_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source (output valid, random_word, input ready);
  modport sink (input valid, random_word, output ready);
endinterface

FILE: design/tgwg_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module tgwg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: design/tgwg_ctrl.sv
// Controller FSM: sequences seed fill and next-word twist, owns result valid.
module tgwg_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_command_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output tgwg_pkg::ctrl_cmd_t    cmd_o,
  input  tgwg_pkg::dp_status_t   status_i
);
  import tgwg_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;
  logic        out_free;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_command_i == CMD_NEXT) ? ST_TWIST : ST_SEED;
        end
      end
      ST_SEED: begin
        if (status_i.seed_last) state_d = ST_IDLE;
      end
      ST_TWIST: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.seed_load  = in_valid_i && (in_command_i == CMD_SEED);
        cmd_o.next_read  = in_valid_i && (in_command_i == CMD_NEXT);
      end
      ST_SEED: begin
        cmd_o.seed_write = 1'b1;
      end
      ST_TWIST: begin
        cmd_o.twist_commit = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.twist_commit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: design/tgwg_datapath.sv
// Datapath: ring RAM, read pointer, seed recurrence, twist and temper logic.
module tgwg_datapath #(
  parameter int unsigned TABLE_WORDS = tgwg_pkg::TGWG_TABLE_WORDS,
  parameter int unsigned TAP_OFFSET  = tgwg_pkg::TGWG_TAP_OFFSET
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [31:0]            seed_value_i,
  input  tgwg_pkg::ctrl_cmd_t    cmd_i,
  output tgwg_pkg::dp_status_t   status_o,
  output logic [31:0]            random_word_o
);
  import tgwg_pkg::*;

  localparam int unsigned AW     = $clog2(TABLE_WORDS);
  localparam int unsigned TapMod = TAP_OFFSET % TABLE_WORDS;

  logic [AW-1:0]     ptr_q, ptr_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic              seeded_q, seeded_d;
  logic [WORD_W-1:0] s_q, s_d;
  logic [WORD_W-1:0] v_q, v_d;
  logic [WORD_W-1:0] word_q, word_d;

  logic [AW-1:0]     ptr_inc;
  logic [AW:0]       tap_sum;
  logic [AW-1:0]     tap_addr;
  logic [WORD_W-1:0] rd_p, rd_t;
  logic [WORD_W-1:0] v_eff, p_eff, t_eff;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              last_idx;

  assign ptr_inc  = (ptr_q == AW'(TABLE_WORDS - 1)) ? '0 : ptr_q + 1'b1;
  assign tap_sum  = {1'b0, ptr_q} + (AW+1)'(TapMod);
  assign tap_addr = (tap_sum >= (AW+1)'(TABLE_WORDS)) ?
                    AW'(tap_sum - (AW+1)'(TABLE_WORDS)) : tap_sum[AW-1:0];
  assign last_idx = (idx_q == AW'(TABLE_WORDS - 1));

  // Until the first seed completes the ring reads as all zeros.
  assign v_eff = seeded_q ? v_q  : '0;
  assign p_eff = seeded_q ? rd_p : '0;
  assign t_eff = seeded_q ? rd_t : '0;

  assign ram_we    = cmd_i.seed_write || cmd_i.twist_commit;
  assign ram_waddr = cmd_i.seed_write ? idx_q : ptr_q;
  assign ram_wdata = cmd_i.seed_write ? s_q : twist(v_eff, p_eff, t_eff);

  tgwg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_WORDS)
  ) u_ring (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (cmd_i.next_read),
    .raddr_a_i (ptr_inc),
    .raddr_b_i (tap_addr),
    .rdata_a_o (rd_p),
    .rdata_b_o (rd_t)
  );

  always_comb begin
    ptr_d    = ptr_q;
    idx_d    = idx_q;
    seeded_d = seeded_q;
    s_d      = s_q;
    v_d      = v_q;
    word_d   = word_q;
    if (cmd_i.seed_load) begin
      s_d   = seed_value_i;
      v_d   = seed_value_i;  // ring[0] after the fill
      idx_d = '0;
    end
    if (cmd_i.seed_write) begin
      s_d   = seed_step(s_q, WORD_W'(idx_q));
      idx_d = idx_q + 1'b1;
      if (last_idx) begin
        seeded_d = 1'b1;
        ptr_d    = '0;
      end
    end
    if (cmd_i.twist_commit) begin
      word_d = temper(v_eff);
      v_d    = p_eff;  // ring[r+1] is untouched, so it is the next v
      ptr_d  = ptr_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      seeded_q <= 1'b0;
    end else begin
      ptr_q    <= ptr_d;
      seeded_q <= seeded_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    s_q    <= s_d;
    v_q    <= v_d;
    word_q <= word_d;
  end

  assign status_o.seed_last = last_idx;
  assign random_word_o      = word_q;

endmodule

FILE: design/twisted_gfsr_word_generator_core.sv
// Next request: accepted in idle; no new request is taken until its result is loaded.
// Its steps are the registered dual-port ring read, then twist write-back and temper.
// Seed request: busy for the whole fill, one ring entry written per cycle, no result.
// A held result does not block acceptance; a stalled result holds the twist step.
// Reset: pointer zero, ring reads as all zeros until the first seed fill completes;
// no clearing pass.
module twisted_gfsr_word_generator_core #(
  parameter int unsigned TABLE_WORDS = tgwg_pkg::TGWG_TABLE_WORDS,
  parameter int unsigned TAP_OFFSET  = tgwg_pkg::TGWG_TAP_OFFSET
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tgwg_req_if.sink          req_i,
  tgwg_rsp_if.source        rsp_o
);
  import tgwg_pkg::*;

  ctrl_cmd_t   cmd;
  dp_status_t  status;
  logic        in_ready;
  logic        out_valid;
  logic [31:0] out_word;

  tgwg_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (req_i.valid),
    .in_command_i (req_i.command),
    .in_ready_o   (in_ready),
    .out_valid_o  (out_valid),
    .out_ready_i  (rsp_o.ready),
    .cmd_o        (cmd),
    .status_i     (status)
  );

  tgwg_datapath #(
    .TABLE_WORDS (TABLE_WORDS),
    .TAP_OFFSET  (TAP_OFFSET)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .seed_value_i  (req_i.seed_value),
    .cmd_i         (cmd),
    .status_o      (status),
    .random_word_o (out_word)
  );

  assign req_i.ready       = in_ready;
  assign rsp_o.valid       = out_valid;
  assign rsp_o.random_word = out_word;

endmodule

FILE: design/tgwg_checker.sv
// Port-level assertions for the generator core, bound to the top level.
module tgwg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        req_command_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [31:0] rsp_word_i
);
  import tgwg_pkg::*;

  logic req_fire;
  assign req_fire = req_valid_i && req_ready_i;

  // every accepted request leaves the block busy, so ready is low right after it
  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> !req_ready_i)
    else $error("ready high right after an accepted request");

  // a next request with the result slot free shows its word after the ring read and twist step
  a_next_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_command_i == CMD_NEXT && (!rsp_valid_i || rsp_ready_i))
      |=> ##1 rsp_valid_i)
    else $error("next result missing two cycles after request");

  a_rsp_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result valid dropped while stalled");

  a_rsp_word_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_word_i))
    else $error("result word changed while stalled");

endmodule

bind twisted_gfsr_word_generator_core tgwg_checker u_tgwg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .req_command_i (req_i.command),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_word_i    (rsp_o.random_word)
);

FILE: test/tgwg_scoreboard.sv
// Scoreboard for the twisted GFSR generator: tracks the word ring and checks result words.
module tgwg_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  tgwg_req_if         req_i,
  tgwg_rsp_if         rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import tgwg_pkg::*;

  localparam int unsigned RING_LEN    = TGWG_TABLE_WORDS;
  localparam int unsigned TAP         = TGWG_TAP_OFFSET;
  localparam int unsigned MAX_REPORTS = 10;

  logic [WORD_W-1:0] word_ring [RING_LEN];
  int unsigned       twist_pos;
  logic [WORD_W-1:0] expected_words [$];
  int unsigned       mismatches;

  function automatic logic [WORD_W-1:0] tempered(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] acc;
    acc = w ^ (w >> 11) ^ (w >> 18);
    acc ^= (w << 7) & TEMPER_B;
    acc ^= (w << 15) & TEMPER_C;
    return acc;
  endfunction

  task automatic reload_ring(input logic [WORD_W-1:0] seed);
    logic [WORD_W-1:0] s;
    s = seed;
    for (int unsigned i = 0; i < RING_LEN; i++) begin
      word_ring[i] = s;
      s = SEED_MULT * ((s ^ (s << 30)) + WORD_W'(i));
    end
    twist_pos = 0;
  endtask

  // Twist the entry at the pointer in place and return the tempered old value.
  task automatic draw_word(output logic [WORD_W-1:0] word);
    logic [WORD_W-1:0] v, p, t, y;
    v = word_ring[twist_pos];
    p = word_ring[(twist_pos + 1) % RING_LEN];
    t = word_ring[(twist_pos + TAP) % RING_LEN];
    y = {v[WORD_W-1], p[WORD_W-2:0]};
    word_ring[twist_pos] = t ^ (y >> 1) ^ (p[0] ? TWIST_XOR : '0);
    twist_pos = (twist_pos + 1 == RING_LEN) ? 0 : twist_pos + 1;
    word = tempered(v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [WORD_W-1:0] want, fresh;
    if (!rst_ni) begin
      foreach (word_ring[i]) word_ring[i] = '0;
      twist_pos = 0;
      expected_words.delete();
      mismatches = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result word %h", $realtime, rsp_i.random_word);
        end else begin
          want = expected_words.pop_front();
          if (rsp_i.random_word !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: random_word expected %h actual %h",
                       $realtime, want, rsp_i.random_word);
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        if (req_i.command == CMD_SEED) begin
          reload_ring(req_i.seed_value);
        end else begin
          draw_word(fresh);
          expected_words.push_back(fresh);
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_words.size();
  end

endmodule

FILE: test/tb_twisted_gfsr_word_generator_core.sv
// Top testbench: drives seed/next requests with random gaps and back-pressure, gives the verdict.
module tb_twisted_gfsr_word_generator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tgwg_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned LONG_RUN     = 700;  // nexts only, so the pointer wraps
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  bit          no_idle = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned fail_count;
  int unsigned pending_count;

  tgwg_req_if req_ch ();
  tgwg_rsp_if rsp_ch ();

  twisted_gfsr_word_generator_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  tgwg_scoreboard u_scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    // now and then a stretch with no idling on either side
    if (cycle_count % 256 == 255) no_idle <= ($urandom_range(0, 3) == 0);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(input logic cmd, input logic [WORD_W-1:0] seed);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.command    <= cmd;
    req_ch.seed_value <= seed;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  // result-side back-pressure
  initial begin
    int unsigned stall;
    rsp_ch.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
      stall = idle_len();
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic              cmd;
    logic [WORD_W-1:0] seed;
    req_ch.valid      = 1'b0;
    req_ch.command    = CMD_NEXT;
    req_ch.seed_value = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // words from the all-zero ring before any seed
    repeat (3) send_request(CMD_NEXT, $urandom);
    send_request(CMD_SEED, '0);
    repeat (4) send_request(CMD_NEXT, '1);
    send_request(CMD_SEED, '1);
    repeat (4) send_request(CMD_NEXT, $urandom);
    // back-to-back seeds, the second one wins
    send_request(CMD_SEED, UPPER_BIT);
    send_request(CMD_SEED, 32'd5489);
    repeat (4) send_request(CMD_NEXT, $urandom);

    for (int unsigned k = 0; k < RANDOM_ITEMS; k++) begin
      cmd = CMD_NEXT;
      if (k == 0 || (k >= LONG_RUN && $urandom_range(0, 31) == 0)) cmd = CMD_SEED;
      case ($urandom_range(0, 7))
        0: seed = '0;
        1: seed = '1;
        default: seed = $urandom;
      endcase
      send_request(cmd, seed);
    end
    req_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
